// ===== rtl/core/gbe_pkg.sv =====
package gbe_pkg;

  // Default store size in bytes.
  localparam int unsigned CapacityDef = 1024;

  // Fixed widths of the command and result fields.
  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 11;
  localparam int unsigned StatusW = 2;

  // Command codes.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR      = 3'd0,
    OP_INSERT     = 3'd1,
    OP_DEL_BEFORE = 3'd2,
    OP_DEL_AT     = 3'd3,
    OP_LEFT       = 3'd4,
    OP_RIGHT      = 3'd5,
    OP_MOVE_TO    = 3'd6,
    OP_READ       = 3'd7
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

// ===== rtl/core/gbe_cmd_if.sv =====
interface gbe_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [gbe_pkg::OpW-1:0]     opcode;
  logic [gbe_pkg::ByteW-1:0]   data_byte;
  logic [gbe_pkg::PosW-1:0]    position;

  modport source (output valid, output opcode, output data_byte, output position,
                  input ready);
  modport sink   (input valid, input opcode, input data_byte, input position,
                  output ready);
endinterface

// ===== rtl/core/gbe_rsp_if.sv =====
interface gbe_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gbe_pkg::StatusW-1:0]  status;
  logic [gbe_pkg::ByteW-1:0]    read_byte;
  logic [gbe_pkg::PosW-1:0]     text_length;
  logic [gbe_pkg::PosW-1:0]     cursor_pos;

  modport source (output valid, output status, output read_byte, output text_length,
                  output cursor_pos, input ready);
  modport sink   (input valid, input status, input read_byte, input text_length,
                  input cursor_pos, output ready);
endinterface

// ===== rtl/core/gap_buffer_editor_core.sv =====
// Sequence: a command beat is captured into the execute state; clear, insert and delete
// register their result there, a read registers its byte from the read-wait state, and a
// cursor move shifts the gap in the move state and then registers its result (left and
// right are moves of one byte). Throughput: one command at a time; the next is taken in
// the cycle after a result is registered. Move-to shifts one byte per cycle through the
// store's write port and registered read port. A waiting result holds the next command in execution.
// Reset (asynchronous, active low) empties the text: cursor 0, gap end at capacity.
// Store contents are not cleared; no command reads a byte it has not written.
module gap_buffer_editor_core #(
  parameter int unsigned CAPACITY = gbe_pkg::CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbe_cmd_if.sink   cmd_i,
  gbe_rsp_if.source rsp_o
);
  import gbe_pkg::*;

  localparam int unsigned PtrW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CmpW  = (PtrW > PosW) ? PtrW : PosW;
  localparam logic [PtrW-1:0] CapPtr = PtrW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MOVE = 4'b0100,
    S_RDWT = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [PtrW-1:0]      gs_q, gs_d;
  logic [PtrW-1:0]      ge_q, ge_d;
  logic [PtrW-1:0]      tgt_q, tgt_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]     wa_q, wa_d;
  op_e                  op_q;
  logic [ByteW-1:0]     byte_q;
  logic [PosW-1:0]      pos_q;

  logic [ByteW-1:0]     mem_q [0:CAPACITY-1];
  logic [ByteW-1:0]     rd_q;
  logic                 mem_re, mem_we;
  logic [AddrW-1:0]     mem_ra, mem_wa;
  logic [ByteW-1:0]     mem_wd;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, res_status;
  logic [ByteW-1:0]     out_byte_q, res_byte;
  logic [PosW-1:0]      out_len_q, out_cur_q;
  logic                 load;

  logic                 accept, out_free;
  logic [PtrW-1:0]      len, len_nxt, gs_m1, ge_m1, rd_far;
  logic [CmpW-1:0]      pos_cmp, len_cmp, gs_cmp, len_nxt_cmp, gs_nxt_cmp;
  logic [PtrW-1:0]      pos_ptr;

  // Handshake and derived quantities.
  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign len     = CapPtr - (ge_q - gs_q);
  assign pos_cmp = CmpW'(pos_q);
  assign len_cmp = CmpW'(len);
  assign gs_cmp  = CmpW'(gs_q);
  assign pos_ptr = pos_cmp[PtrW-1:0];
  assign gs_m1   = gs_q - 1'b1;
  assign ge_m1   = ge_q - 1'b1;
  assign rd_far  = ge_q + pos_ptr - gs_q;

  // Command sequencer: pointer updates, store accesses and result capture.
  always_comb begin
    state_d    = state_q;
    gs_d       = gs_q;
    ge_d       = ge_q;
    tgt_d      = tgt_q;
    wa_d       = wa_q;
    wr_pend_d  = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    mem_we     = wr_pend_q;
    mem_wa     = wa_q;
    mem_wd     = rd_q;
    load       = 1'b0;
    res_status = ST_OK;
    res_byte   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          unique case (op_q)
            OP_CLEAR: begin
              gs_d = '0;
              ge_d = CapPtr;
            end
            OP_INSERT: begin
              if (gs_q == ge_q) begin
                res_status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = gs_q[AddrW-1:0];
                mem_wd = byte_q;
                gs_d   = gs_q + 1'b1;
              end
            end
            OP_DEL_BEFORE: begin
              if (gs_q != '0) begin
                gs_d = gs_m1;
              end
            end
            OP_DEL_AT: begin
              if (ge_q != CapPtr) begin
                ge_d = ge_q + 1'b1;
              end
            end
            OP_LEFT: begin
              if (gs_q != '0) begin
                load    = 1'b0;
                tgt_d   = gs_m1;
                state_d = S_MOVE;
              end
            end
            OP_RIGHT: begin
              if (ge_q != CapPtr) begin
                load    = 1'b0;
                tgt_d   = gs_q + 1'b1;
                state_d = S_MOVE;
              end
            end
            OP_MOVE_TO: begin
              if (pos_cmp > len_cmp) begin
                res_status = ST_RANGE;
              end else begin
                load    = 1'b0;
                tgt_d   = pos_ptr;
                state_d = S_MOVE;
              end
            end
            OP_READ: begin
              if (pos_cmp >= len_cmp) begin
                res_status = ST_RANGE;
              end else begin
                load    = 1'b0;
                mem_re  = 1'b1;
                mem_ra  = (pos_cmp < gs_cmp) ? pos_ptr[AddrW-1:0] : rd_far[AddrW-1:0];
                state_d = S_RDWT;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        // One byte crosses the gap per cycle; its write lands in the next cycle.
        if (gs_q > tgt_q) begin
          mem_re    = 1'b1;
          mem_ra    = gs_m1[AddrW-1:0];
          wa_d      = ge_m1[AddrW-1:0];
          wr_pend_d = 1'b1;
          gs_d      = gs_m1;
          ge_d      = ge_m1;
        end else if (gs_q < tgt_q) begin
          mem_re    = 1'b1;
          mem_ra    = ge_q[AddrW-1:0];
          wa_d      = gs_q[AddrW-1:0];
          wr_pend_d = 1'b1;
          gs_d      = gs_q + 1'b1;
          ge_d      = ge_q + 1'b1;
        end else if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RDWT: begin
        if (out_free) begin
          res_byte = rd_q;
          load     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Length and cursor as they stand after the command.
  assign len_nxt     = CapPtr - (ge_d - gs_d);
  assign len_nxt_cmp = CmpW'(len_nxt);
  assign gs_nxt_cmp  = CmpW'(gs_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gs_q        <= '0;
      ge_q        <= CapPtr;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gs_q        <= gs_d;
      ge_q        <= ge_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command beat capture and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(cmd_i.opcode);
      byte_q <= cmd_i.data_byte;
      pos_q  <= cmd_i.position;
    end
    tgt_q <= tgt_d;
    wa_q  <= wa_d;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= res_status;
      out_byte_q   <= res_byte;
      out_len_q    <= len_nxt_cmp[PosW-1:0];
      out_cur_q    <= gs_nxt_cmp[PosW-1:0];
    end
  end

  // Text store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_byte   = out_byte_q;
  assign rsp_o.text_length = out_len_q;
  assign rsp_o.cursor_pos  = out_cur_q;

  // The gap never inverts and never runs past the top of the store.
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gs_q <= ge_q) && (ge_q <= CapPtr))
    else $error("gap pointers out of order");

  // A deferred write belongs to a gap shift.
  a_pend_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_MOVE))
    else $error("deferred store write outside a gap shift");

  // Shifting the gap keeps its width.
  a_move_keeps_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=> ((ge_q - gs_q) == $past(ge_q - gs_q)))
    else $error("gap width changed during a shift");

  // A shift never overshoots its target.
  a_move_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MOVE) && (gs_q > tgt_q)) |=> (gs_q >= tgt_q))
    else $error("cursor overshot the move target");

  // A result is only registered when the result slot is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result beat overwritten before it was taken");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gbe_pkg::*;

  localparam int unsigned CAP = CapacityDef;
  // The longest quiet spell is one full-length move-to plus a stall on each side.
  localparam int unsigned STALL_LIMIT = 8 * CAP;

  // Expected content of one result beat.
  typedef struct packed {
    status_e            status;
    logic [ByteW-1:0]   read_byte;
    logic [PosW-1:0]    text_length;
    logic [PosW-1:0]    cursor_pos;
  } edit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gbe_cmd_if cmd_bus ();
  gbe_rsp_if rsp_bus ();

  gap_buffer_editor_core #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow copy of the gap buffer and the results it has produced so far.
  logic [ByteW-1:0] shadow_text [CAP];
  int unsigned      shadow_gap_start = 0;
  int unsigned      shadow_gap_end = CAP;
  edit_result_t     edit_results [$];

  int  error_count = 0;
  int  quiet_cycles = 0;
  bit  idle_en = 1'b1;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned shadow_length();
    return CAP - (shadow_gap_end - shadow_gap_start);
  endfunction

  // Moving the gap left carries the byte before the cursor across to the top.
  function automatic void shift_gap_left();
    if (shadow_gap_start != 0) begin
      shadow_gap_start--;
      shadow_gap_end--;
      shadow_text[shadow_gap_end] = shadow_text[shadow_gap_start];
    end
  endfunction

  function automatic void shift_gap_right();
    if (shadow_gap_end < CAP) begin
      shadow_text[shadow_gap_start] = shadow_text[shadow_gap_end];
      shadow_gap_start++;
      shadow_gap_end++;
    end
  endfunction

  // Applies one command to the shadow buffer and returns the result it gives.
  function automatic edit_result_t apply_edit(op_e op, logic [ByteW-1:0] db,
                                              logic [PosW-1:0] pos);
    edit_result_t res;
    int unsigned  p;
    p = 32'(pos);
    res.status = ST_OK;
    res.read_byte = '0;
    case (op)
      OP_CLEAR: begin
        shadow_gap_start = 0;
        shadow_gap_end = CAP;
      end
      OP_INSERT: begin
        if (shadow_gap_start >= shadow_gap_end) begin
          res.status = ST_FULL;
        end else begin
          shadow_text[shadow_gap_start] = db;
          shadow_gap_start++;
        end
      end
      OP_DEL_BEFORE: begin
        if (shadow_gap_start > 0) shadow_gap_start--;
      end
      OP_DEL_AT: begin
        if (shadow_gap_end < CAP) shadow_gap_end++;
      end
      OP_LEFT:  shift_gap_left();
      OP_RIGHT: shift_gap_right();
      OP_MOVE_TO: begin
        if (p > shadow_length()) begin
          res.status = ST_RANGE;
        end else begin
          while (shadow_gap_start > p) shift_gap_left();
          while (shadow_gap_start < p) shift_gap_right();
        end
      end
      default: begin
        if (p >= shadow_length()) begin
          res.status = ST_RANGE;
        end else if (p < shadow_gap_start) begin
          res.read_byte = shadow_text[p];
        end else begin
          res.read_byte = shadow_text[shadow_gap_end + (p - shadow_gap_start)];
        end
      end
    endcase
    res.text_length = PosW'(shadow_length());
    res.cursor_pos = PosW'(shadow_gap_start);
    return res;
  endfunction

  // Sends one command beat, with an occasional idle burst in front of it.
  task automatic send_cmd(op_e op, logic [ByteW-1:0] db, logic [PosW-1:0] pos);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.opcode <= op;
    cmd_bus.data_byte <= db;
    cmd_bus.position <= pos;
    do @(posedge clk_i); while (!cmd_bus.ready);
    edit_results.push_back(apply_edit(op, db, pos));
  endtask

  // Holds the command side back until every outstanding result has arrived.
  task automatic wait_results_drained();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (edit_results.size() != 0) @(posedge clk_i);
  endtask

  // Boundary commands on an empty and a short text, with extreme field values.
  task automatic test_directed_edges();
    send_cmd(OP_DEL_BEFORE, 8'hFF, 11'h7FF);
    send_cmd(OP_DEL_AT, 8'h00, 11'h000);
    send_cmd(OP_LEFT, 8'hFF, 11'h7FF);
    send_cmd(OP_RIGHT, 8'h00, 11'h000);
    send_cmd(OP_READ, 8'hFF, 11'd0);
    send_cmd(OP_MOVE_TO, 8'h00, 11'd0);
    send_cmd(OP_MOVE_TO, 8'hFF, 11'd1);
    send_cmd(OP_INSERT, 8'h00, 11'h7FF);
    send_cmd(OP_INSERT, 8'hFF, 11'h000);
    send_cmd(OP_INSERT, 8'h5A, 11'h555);
    send_cmd(OP_READ, 8'h00, 11'd2);
    send_cmd(OP_LEFT, 8'h00, 11'd0);
    send_cmd(OP_READ, 8'hFF, 11'd2);
    send_cmd(OP_READ, 8'h00, 11'd3);
    send_cmd(OP_READ, 8'h00, 11'h7FF);
    send_cmd(OP_MOVE_TO, 8'h00, 11'd0);
    send_cmd(OP_RIGHT, 8'h00, 11'h2AA);
    send_cmd(OP_DEL_AT, 8'hFF, 11'h7FF);
    send_cmd(OP_DEL_BEFORE, 8'h00, 11'h000);
    send_cmd(OP_MOVE_TO, 8'h00, 11'h400);
    send_cmd(OP_MOVE_TO, 8'h00, 11'd1);
    send_cmd(OP_CLEAR, 8'hFF, 11'h7FF);
    send_cmd(OP_READ, 8'h00, 11'd0);
  endtask

  // Fills the store to capacity and exercises the full case from both ends.
  task automatic test_fill_to_capacity();
    wait_results_drained();
    send_cmd(OP_CLEAR, 8'h00, 11'd0);
    repeat (CAP) send_cmd(OP_INSERT, ByteW'($urandom), PosW'($urandom));
    send_cmd(OP_INSERT, 8'hA5, 11'd0);
    send_cmd(OP_MOVE_TO, 8'h00, 11'd0);
    send_cmd(OP_INSERT, 8'h11, 11'd0);
    send_cmd(OP_READ, 8'h00, 11'd0);
    send_cmd(OP_READ, 8'h00, PosW'(CAP - 1));
    send_cmd(OP_READ, 8'h00, PosW'(CAP));
    send_cmd(OP_MOVE_TO, 8'h00, PosW'(CAP / 2));
    send_cmd(OP_DEL_AT, 8'h00, 11'd0);
    send_cmd(OP_INSERT, 8'h3C, 11'd0);
    send_cmd(OP_INSERT, 8'hC3, 11'd0);
    send_cmd(OP_MOVE_TO, 8'h00, PosW'(CAP));
    send_cmd(OP_RIGHT, 8'h00, 11'd0);
    send_cmd(OP_READ, 8'h00, PosW'(CAP - 1));
    send_cmd(OP_MOVE_TO, 8'h00, PosW'(CAP + 1));
    send_cmd(OP_CLEAR, 8'h00, 11'd0);
  endtask

  // Random editing in phases, each steering the text towards a length of its own.
  task automatic test_random_edits();
    int unsigned targets [5] = '{4, 40, 200, 600, CAP};
    int unsigned target;
    int unsigned len;
    int          sent;
    int          r;
    int          k;
    int          p;
    int          n;
    bit          grow;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0 || $urandom_range(0, 3) == 0) wait_results_drained();
      // The closing phase runs flat out on both sides.
      if (phase == 7) idle_en = 1'b0;
      target = targets[$urandom_range(0, 4)];
      sent = 0;
      while (sent < 115) begin
        len = shadow_length();
        grow = (len < target);
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        if (r == 0) begin
          send_cmd(OP_CLEAR, ByteW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < 5) begin
          // A typing run: a string of inserts at the cursor.
          n = $urandom_range(1, 40);
          repeat (n) send_cmd(OP_INSERT, ByteW'($urandom), PosW'($urandom));
          sent += n;
        end else if (r < (grow ? 45 : 15)) begin
          send_cmd(OP_INSERT, ByteW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < (grow ? 50 : 30)) begin
          send_cmd(OP_DEL_BEFORE, ByteW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < (grow ? 55 : 45)) begin
          send_cmd(OP_DEL_AT, ByteW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < 63) begin
          send_cmd(OP_LEFT, ByteW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < 71) begin
          send_cmd(OP_RIGHT, ByteW'($urandom), PosW'($urandom));
          sent++;
        end else if (r < 82) begin
          // Mostly short hops around the cursor, now and then a long walk.
          if (k < 7) begin
            p = int'(shadow_gap_start) + $urandom_range(0, 16) - 8;
            if (p < 0) p = 0;
            if (p > int'(len)) p = int'(len);
          end else if (k < 9) begin
            p = $urandom_range(0, len);
          end else begin
            p = $urandom_range(0, 2047);
          end
          send_cmd(OP_MOVE_TO, ByteW'($urandom), PosW'(p));
          sent++;
        end else begin
          if (k < 8) begin
            p = (len == 0) ? 0 : $urandom_range(0, len - 1);
          end else if (k == 8) begin
            p = int'(len);
          end else begin
            p = $urandom_range(0, 2047);
          end
          send_cmd(OP_READ, ByteW'($urandom), PosW'(p));
          sent++;
        end
      end
    end
  endtask

  // Result side: ready with random stall bursts.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Each result beat is compared with the oldest expected result.
  always @(posedge clk_i) begin : check_results
    edit_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (edit_results.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d length %0d cursor %0d", $time,
                 rsp_bus.status, rsp_bus.text_length, rsp_bus.cursor_pos);
        error_count++;
      end else begin
        want = edit_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status,
                   rsp_bus.status);
          error_count++;
        end
        if (rsp_bus.read_byte !== want.read_byte) begin
          $display("%0t: read_byte expected 0x%02h, actual 0x%02h", $time,
                   want.read_byte, rsp_bus.read_byte);
          error_count++;
        end
        if (rsp_bus.text_length !== want.text_length) begin
          $display("%0t: text_length expected %0d, actual %0d", $time, want.text_length,
                   rsp_bus.text_length);
          error_count++;
        end
        if (rsp_bus.cursor_pos !== want.cursor_pos) begin
          $display("%0t: cursor_pos expected %0d, actual %0d", $time, want.cursor_pos,
                   rsp_bus.cursor_pos);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst_ni <= 1'b0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.opcode <= OP_CLEAR;
    cmd_bus.data_byte <= '0;
    cmd_bus.position <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_fill_to_capacity();
    test_random_edits();

    // Let the last results arrive, then watch for any stray beat.
    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gbe_pkg.sv
rtl/core/gbe_cmd_if.sv
rtl/core/gbe_rsp_if.sv
rtl/core/gap_buffer_editor_core.sv
bench/tb_top.sv
